/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the URL authority parser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define UAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define UAP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/uap_pkg.sv */
// ---------------------------------------------------------------------------
// URL authority parser package
// Types, codes and character helpers shared by the parser modules.
// ---------------------------------------------------------------------------
package uap_pkg;

    localparam int OFF_W  = 13;
    localparam int ACC_W  = 17;
    localparam int PORT_W = 16;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_EMPTY  = 3'd1;
    localparam logic [2:0] ERR_SCHEME = 3'd2;
    localparam logic [2:0] ERR_PORT   = 3'd3;
    localparam logic [2:0] ERR_JUNK   = 3'd4;
    localparam logic [2:0] ERR_LONG   = 3'd5;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_OTHER = 2'd1;
    localparam logic [1:0] KIND_HTTP  = 2'd2;
    localparam logic [1:0] KIND_HTTPS = 2'd3;

    localparam logic [PORT_W-1:0] PORT_HTTP  = 16'd80;
    localparam logic [PORT_W-1:0] PORT_HTTPS = 16'd443;
    localparam logic [20:0]       PORT_LIMIT = 21'h00ffff;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        PH_START,
        PH_HOST,
        PH_COLON,
        PH_COLSLASH,
        PH_PORT,
        PH_PATH
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
        logic       is_empty;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        error_code;
        logic [1:0]        scheme_kind;
        logic [OFF_W-1:0]  scheme_len;
        logic [OFF_W-1:0]  host_start;
        logic [OFF_W-1:0]  host_len;
        logic [PORT_W-1:0] port_value;
        logic              port_given;
        logic [OFF_W-1:0]  path_start;
        logic [OFF_W-1:0]  path_len;
    } t_result;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_scheme_char(logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
    endfunction

    // Characters of the text "https" by position.
    function automatic logic [7:0] https_char(logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h68;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h70;
            3'd4:    c = 8'h73;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/uap_stream_if.sv */
// ---------------------------------------------------------------------------
// Stream interface
// Valid/ready channel that carries one payload per transaction.
// ---------------------------------------------------------------------------
interface uap_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/uap_in_stage.sv */
// ---------------------------------------------------------------------------
// Input register stage
// Registers each incoming byte transaction ahead of the parser.
// ---------------------------------------------------------------------------
module uap_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uap_stream_if.sink    i_in,
    uap_stream_if.source  o_out
);

    logic              r_valid;
    uap_pkg::t_in_item r_data;

    assign i_in.ready  = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data <= i_in.data;
        end
    end

endmodule

/* hw/rtl/uap_parser.sv */
// ---------------------------------------------------------------------------
// URL parser core
// Per-byte scan state, span bookkeeping and the registered result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module uap_parser #(
    parameter int MAX_URL_LEN = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uap_stream_if.sink    i_in,
    uap_stream_if.source  o_out
);

    localparam int PW = $clog2(MAX_URL_LEN + 2);
    localparam int OW = uap_pkg::OFF_W;
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_URL_LEN);

    function automatic logic [OW-1:0] to_off(logic [PW-1:0] v);
        logic [PW+OW-1:0] wide;
        wide = {{OW{1'b0}}, v};
        return wide[OW-1:0];
    endfunction

    uap_pkg::t_phase              r_phase, n_phase;
    logic [PW-1:0]                r_pos, n_pos;
    logic                         r_scheme_ok, n_scheme_ok;
    logic [PW-1:0]                r_colon_off, n_colon_off;
    logic                         r_http_match, n_http_match;
    logic [PW-1:0]                r_host_begin, n_host_begin;
    logic [PW-1:0]                r_host_len, n_host_len;
    logic [uap_pkg::ACC_W-1:0]    r_port_acc, n_port_acc;
    logic [PW-1:0]                r_path_begin, n_path_begin;
    logic [2:0]                   r_err, n_err;
    logic [1:0]                   r_kind, n_kind;
    logic                         r_port_seen, n_port_seen;
    logic                         r_path_valid, n_path_valid;

    logic                         r_out_valid;
    uap_pkg::t_result             r_out;

    logic                         w_adv;
    logic                         w_emit;
    logic                         w_restart;
    uap_pkg::t_result             w_res;
    logic [7:0]                   w_ch;
    logic [3:0]                   w_digit;
    logic [20:0]                  w_port_next;
    logic [PW-1:0]                w_total;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_adv       = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_ch        = i_in.data.ch;
    assign w_digit     = w_ch[3:0];
    assign w_port_next = 21'({r_port_acc, 3'b000}) + 21'({r_port_acc, 1'b0}) + 21'(w_digit);
    assign w_total     = r_pos + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_scheme_ok  = r_scheme_ok;
        n_colon_off  = r_colon_off;
        n_http_match = r_http_match;
        n_host_begin = r_host_begin;
        n_host_len   = r_host_len;
        n_port_acc   = r_port_acc;
        n_path_begin = r_path_begin;
        n_err        = r_err;
        n_kind       = r_kind;
        n_port_seen  = r_port_seen;
        n_path_valid = r_path_valid;
        w_emit       = 1'b0;
        w_restart    = 1'b0;
        w_res        = '0;

        if (i_in.data.is_empty) begin
            w_emit           = 1'b1;
            w_restart        = 1'b1;
            w_res.error_code = uap_pkg::ERR_EMPTY;
        end else begin
            if (r_pos <= MAX_POS) begin
                n_pos = r_pos + 1'b1;
            end
            if (r_pos >= MAX_POS && r_err == uap_pkg::ERR_NONE) begin
                n_err = uap_pkg::ERR_LONG;
            end
            if (n_err == uap_pkg::ERR_NONE) begin
                unique case (r_phase)
                    uap_pkg::PH_START: begin
                        if (!uap_pkg::is_letter(w_ch)) begin
                            n_err = uap_pkg::ERR_SCHEME;
                        end else begin
                            n_http_match = (w_ch == uap_pkg::https_char(3'd0));
                            n_phase      = uap_pkg::PH_HOST;
                        end
                    end
                    uap_pkg::PH_HOST: begin
                        if (w_ch == uap_pkg::CH_COLON) begin
                            n_host_len  = r_pos - r_host_begin;
                            n_port_seen = 1'b1;
                            n_port_acc  = '0;
                            if (r_scheme_ok) begin
                                n_colon_off = r_pos;
                                n_phase     = uap_pkg::PH_COLON;
                            end else begin
                                n_phase = uap_pkg::PH_PORT;
                            end
                        end else if (w_ch == uap_pkg::CH_SLASH) begin
                            n_host_len   = r_pos - r_host_begin;
                            n_path_begin = r_pos;
                            n_path_valid = 1'b1;
                            n_phase      = uap_pkg::PH_PATH;
                        end else if (r_scheme_ok) begin
                            if (!uap_pkg::is_scheme_char(w_ch)) begin
                                n_scheme_ok  = 1'b0;
                                n_http_match = 1'b0;
                            end else if (r_pos >= PW'(5) ||
                                         w_ch != uap_pkg::https_char(r_pos[2:0])) begin
                                n_http_match = 1'b0;
                            end
                        end
                    end
                    uap_pkg::PH_COLON: begin
                        n_scheme_ok = 1'b0;
                        if (w_ch == uap_pkg::CH_SLASH) begin
                            n_path_begin = r_pos;
                            n_path_valid = 1'b1;
                            n_phase      = uap_pkg::PH_COLSLASH;
                        end else if (uap_pkg::is_digit(w_ch)) begin
                            n_port_acc = uap_pkg::ACC_W'(w_digit);
                            n_phase    = uap_pkg::PH_PORT;
                        end else begin
                            n_err = uap_pkg::ERR_JUNK;
                        end
                    end
                    uap_pkg::PH_COLSLASH: begin
                        if (w_ch == uap_pkg::CH_SLASH) begin
                            if (r_http_match && r_colon_off == PW'(5)) begin
                                n_kind = uap_pkg::KIND_HTTPS;
                            end else if (r_http_match && r_colon_off == PW'(4)) begin
                                n_kind = uap_pkg::KIND_HTTP;
                            end else begin
                                n_kind = uap_pkg::KIND_OTHER;
                            end
                            n_port_seen  = 1'b0;
                            n_path_valid = 1'b0;
                            n_path_begin = '0;
                            n_host_begin = r_pos + 1'b1;
                            n_host_len   = '0;
                            n_phase      = uap_pkg::PH_HOST;
                        end else begin
                            n_phase = uap_pkg::PH_PATH;
                        end
                    end
                    uap_pkg::PH_PORT: begin
                        if (uap_pkg::is_digit(w_ch)) begin
                            n_port_acc = w_port_next[uap_pkg::ACC_W-1:0];
                            if (w_port_next > uap_pkg::PORT_LIMIT) begin
                                n_err = uap_pkg::ERR_PORT;
                            end
                        end else if (w_ch == uap_pkg::CH_SLASH) begin
                            n_path_begin = r_pos;
                            n_path_valid = 1'b1;
                            n_phase      = uap_pkg::PH_PATH;
                        end else begin
                            n_err = uap_pkg::ERR_JUNK;
                        end
                    end
                    uap_pkg::PH_PATH: begin
                    end
                    default: begin
                    end
                endcase
            end

            if (i_in.data.is_last) begin
                w_emit    = 1'b1;
                w_restart = 1'b1;
                if (n_err != uap_pkg::ERR_NONE) begin
                    w_res.error_code = n_err;
                end else begin
                    w_res.scheme_kind = n_kind;
                    w_res.scheme_len  = (n_kind != uap_pkg::KIND_NONE) ?
                                        to_off(n_colon_off) : '0;
                    w_res.host_start  = to_off(n_host_begin);
                    w_res.host_len    = (n_phase == uap_pkg::PH_HOST) ?
                                        to_off(w_total - n_host_begin) : to_off(n_host_len);
                    if (n_port_seen) begin
                        w_res.port_value = n_port_acc[uap_pkg::PORT_W-1:0];
                    end else if (n_kind == uap_pkg::KIND_HTTPS) begin
                        w_res.port_value = uap_pkg::PORT_HTTPS;
                    end else if (n_kind == uap_pkg::KIND_HTTP) begin
                        w_res.port_value = uap_pkg::PORT_HTTP;
                    end
                    w_res.port_given = n_port_seen;
                    if (n_path_valid) begin
                        w_res.path_start = to_off(n_path_begin);
                        w_res.path_len   = to_off(w_total - n_path_begin);
                    end
                end
            end
        end

        if (w_restart) begin
            n_phase      = uap_pkg::PH_START;
            n_pos        = '0;
            n_scheme_ok  = 1'b1;
            n_colon_off  = '0;
            n_http_match = 1'b1;
            n_host_begin = '0;
            n_host_len   = '0;
            n_port_acc   = '0;
            n_path_begin = '0;
            n_err        = uap_pkg::ERR_NONE;
            n_kind       = uap_pkg::KIND_NONE;
            n_port_seen  = 1'b0;
            n_path_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= uap_pkg::PH_START;
            r_pos        <= '0;
            r_scheme_ok  <= 1'b1;
            r_colon_off  <= '0;
            r_http_match <= 1'b1;
            r_host_begin <= '0;
            r_host_len   <= '0;
            r_port_acc   <= '0;
            r_path_begin <= '0;
            r_err        <= uap_pkg::ERR_NONE;
            r_kind       <= uap_pkg::KIND_NONE;
            r_port_seen  <= 1'b0;
            r_path_valid <= 1'b0;
        end else if (w_adv) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_scheme_ok  <= n_scheme_ok;
            r_colon_off  <= n_colon_off;
            r_http_match <= n_http_match;
            r_host_begin <= n_host_begin;
            r_host_len   <= n_host_len;
            r_port_acc   <= n_port_acc;
            r_path_begin <= n_path_begin;
            r_err        <= n_err;
            r_kind       <= n_kind;
            r_port_seen  <= n_port_seen;
            r_path_valid <= n_path_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

    `UAP_ASSERT_IMP(a_err_clears_fields, i_clk, i_rst_n,
        r_out_valid && r_out.error_code != uap_pkg::ERR_NONE,
        r_out.scheme_kind == uap_pkg::KIND_NONE && r_out.host_len == '0 && r_out.port_value == '0 && r_out.path_len == '0,
        "Error result carries nonzero fields.")
    `UAP_ASSERT_IMP(a_https_default_port, i_clk, i_rst_n,
        r_out_valid && r_out.error_code == uap_pkg::ERR_NONE && !r_out.port_given && r_out.scheme_kind == uap_pkg::KIND_HTTPS,
        r_out.port_value == uap_pkg::PORT_HTTPS,
        "HTTPS result without explicit port lacks the default port.")
    `UAP_ASSERT_IMP(a_path_after_start, i_clk, i_rst_n,
        r_out_valid && r_out.error_code == uap_pkg::ERR_NONE && r_out.path_len != '0,
        r_out.path_start != '0,
        "A path cannot begin at the first byte.")
    `UAP_ASSERT_NXT(a_restart_after_end, i_clk, i_rst_n,
        w_adv && (i_in.data.is_last || i_in.data.is_empty),
        r_phase == uap_pkg::PH_START && r_pos == '0 && r_err == uap_pkg::ERR_NONE,
        "Scan state did not return to start after the final transaction.")

endmodule

/* hw/rtl/url_authority_parser_top.sv */
// The final byte is held in the input register; its result is then held in the result register.
// Throughput: one byte per cycle unless a waiting result is not taken.
// The input register and the result register let a byte enter while a result waits.
// Reset is synchronous and active low; it clears the scan state and both valid flags.
// ---------------------------------------------------------------------------
// URL authority parser
// Splits a byte stream URL into scheme, host, port and path spans.
// ---------------------------------------------------------------------------
module url_authority_parser_top #(
    parameter int MAX_URL_LEN = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uap_stream_if.sink    i_in,
    uap_stream_if.source  o_out
);

    uap_stream_if #(.T(uap_pkg::t_in_item)) s_byte ();

    uap_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (s_byte.source)
    );

    uap_parser #(
        .MAX_URL_LEN (MAX_URL_LEN)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (s_byte.sink),
        .o_out   (o_out)
    );

endmodule
